@@ src/budc_pkg.sv @@
package budc_pkg;

    // Controller states, one-hot coded.
    typedef enum logic [4:0] {
        ST_START = 5'b00001,
        ST_WAIT  = 5'b00010,
        ST_INC   = 5'b00100,
        ST_DEC   = 5'b01000,
        ST_CLEAR = 5'b10000
    } budc_state_t;

    // Auto-repeat phase: polling every tick, slow repeat, fast repeat.
    typedef enum logic [1:0] {
        PHASE_POLL = 2'd0,
        PHASE_SLOW = 2'd1,
        PHASE_FAST = 2'd2,
        PHASE_IDLE = 2'd3
    } budc_phase_t;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 5;

    typedef logic [TIME_W-1:0]  budc_time_t;
    typedef logic [COUNT_W-1:0] budc_count_t;

    // Register indexes; the byte address is four times the index.
    typedef enum logic [2:0] {
        REG_HOLD_DELAY  = 3'd0,
        REG_SLOW_REPEAT = 3'd1,
        REG_FAST_AFTER  = 3'd2,
        REG_FAST_REPEAT = 3'd3,
        REG_TOP_COUNT   = 3'd4
    } budc_reg_idx_t;

    localparam budc_time_t  HOLD_DELAY_RST  = 16'd1000;
    localparam budc_time_t  SLOW_REPEAT_RST = 16'd1000;
    localparam budc_time_t  FAST_AFTER_RST  = 16'd3000;
    localparam budc_time_t  FAST_REPEAT_RST = 16'd400;
    localparam budc_count_t TOP_COUNT_RST   = 4'd9;

    localparam budc_time_t  TIME_MAX        = 16'hFFFF;
    localparam budc_time_t  ELAPSED_RST     = 16'd1;
    localparam budc_time_t  POLL_PERIOD     = 16'd1;

endpackage

@@ src/budc_in_if.sv @@
interface budc_in_if;
    import budc_pkg::*;

    logic valid;
    logic ready;
    logic button_up;
    logic button_down;

    modport source (output valid, output button_up, output button_down, input ready);
    modport sink   (input valid, input button_up, input button_down, output ready);

endinterface

@@ src/budc_out_if.sv @@
interface budc_out_if;
    import budc_pkg::*;

    logic        valid;
    logic        ready;
    budc_count_t count_value;

    modport source (output valid, output count_value, input ready);
    modport sink   (input valid, input count_value, output ready);

endinterface

@@ src/button_updown_counter_autorepeat.sv @@
// Channel    | Direction | Payload                       | Handshake
// -----------+-----------+-------------------------------+------------------------
// in_ch      | sink      | button_up, button_down (1 ea) | valid/ready, one tick
// out_ch     | source    | count_value (4)               | valid/ready, one count
// apb        | slave     | 5 config registers at 4*i     | psel/penable, pready=1
//
// Each input transaction is one millisecond tick and produces exactly one
// output transaction in the following cycle, through a single result register.
// A new tick is accepted in every cycle while the result register is empty
// or being drained, so the sustained rate is one transaction per cycle.
// The whole controller update is one pass of combinational logic between
// the state registers and the result register.
// Reset is asynchronous and active low; it clears state and configuration.
// A stall on out_ch holds the result and backpressures in_ch directly.
module button_updown_counter_autorepeat
    import budc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    budc_in_if.sink             in_ch,
    budc_out_if.source          out_ch
);

    // Configuration registers.
    budc_time_t  hold_delay_reg;
    budc_time_t  slow_repeat_reg;
    budc_time_t  fast_after_reg;
    budc_time_t  fast_repeat_reg;
    budc_count_t top_count_reg;

    // Controller state.
    budc_state_t state_reg, state_next;
    budc_count_t count_reg, count_next;
    budc_phase_t phase_reg, phase_next;
    budc_time_t  elapsed_reg, elapsed_next;
    budc_time_t  hold_reg, hold_next;

    // Result register.
    logic        out_valid_reg;
    budc_count_t out_count_reg;

    logic          in_accept;
    logic          cfg_write;
    budc_reg_idx_t cfg_idx;

    assign cfg_idx   = budc_reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // The input side only stalls when a finished count is still waiting.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.count_value = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_delay_reg  <= HOLD_DELAY_RST;
            slow_repeat_reg <= SLOW_REPEAT_RST;
            fast_after_reg  <= FAST_AFTER_RST;
            fast_repeat_reg <= FAST_REPEAT_RST;
            top_count_reg   <= TOP_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_HOLD_DELAY:  hold_delay_reg  <= pwdata[TIME_W-1:0];
                REG_SLOW_REPEAT: slow_repeat_reg <= pwdata[TIME_W-1:0];
                REG_FAST_AFTER:  fast_after_reg  <= pwdata[TIME_W-1:0];
                REG_FAST_REPEAT: fast_repeat_reg <= pwdata[TIME_W-1:0];
                REG_TOP_COUNT:   top_count_reg   <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_HOLD_DELAY:  prdata = {{(DATA_W-TIME_W){1'b0}}, hold_delay_reg};
            REG_SLOW_REPEAT: prdata = {{(DATA_W-TIME_W){1'b0}}, slow_repeat_reg};
            REG_FAST_AFTER:  prdata = {{(DATA_W-TIME_W){1'b0}}, fast_after_reg};
            REG_FAST_REPEAT: prdata = {{(DATA_W-TIME_W){1'b0}}, fast_repeat_reg};
            REG_TOP_COUNT:   prdata = {{(DATA_W-COUNT_W){1'b0}}, top_count_reg};
            default:         prdata = '0;
        endcase
    end

    // One tick of the controller. The state machine is only evaluated when
    // the elapsed tick count has reached the period of the current phase.
    always_comb
    begin
        logic        up;
        logic        dn;
        logic        evaluate;
        logic        step_en;
        logic        can_inc;
        logic        can_dec;
        budc_time_t  period;
        budc_phase_t phase_mid;
        budc_time_t  elapsed_mid;
        budc_time_t  hold_mid;

        up = in_ch.button_up;
        dn = in_ch.button_down;

        case (phase_reg)
            PHASE_SLOW: period = slow_repeat_reg;
            PHASE_FAST: period = fast_repeat_reg;
            default:    period = POLL_PERIOD;
        endcase
        evaluate = (elapsed_reg >= period);

        can_inc = (count_reg < top_count_reg);
        can_dec = (count_reg != '0);

        // Phase advance while a single button is held.
        phase_mid = phase_reg;
        if (phase_reg == PHASE_SLOW && hold_reg >= fast_after_reg)
        begin
            phase_mid = PHASE_FAST;
        end
        else if (phase_reg == PHASE_POLL && hold_reg >= hold_delay_reg)
        begin
            phase_mid = PHASE_SLOW;
        end
        step_en = (phase_mid == PHASE_SLOW) || (phase_mid == PHASE_FAST);

        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        hold_mid   = hold_reg;

        if (evaluate)
        begin
            case (state_reg)
                ST_WAIT:
                begin
                    if (up && !dn)
                    begin
                        state_next = ST_INC;
                    end
                    else if (!up && dn)
                    begin
                        state_next = ST_DEC;
                    end
                    else if (up && dn)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
                ST_INC:
                begin
                    if (up && !dn)
                    begin
                        phase_next = phase_mid;
                        if (step_en && can_inc)
                        begin
                            count_next = count_reg + budc_count_t'(1);
                        end
                    end
                    else if (up && dn)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        // Release: one step, then back to waiting.
                        state_next = ST_WAIT;
                        if (can_inc)
                        begin
                            count_next = count_reg + budc_count_t'(1);
                        end
                    end
                end
                ST_DEC:
                begin
                    if (!up && dn)
                    begin
                        phase_next = phase_mid;
                        if (step_en && can_dec)
                        begin
                            count_next = count_reg - budc_count_t'(1);
                        end
                    end
                    else if (up && dn)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                        if (can_dec)
                        begin
                            count_next = count_reg - budc_count_t'(1);
                        end
                    end
                end
                ST_CLEAR:
                begin
                    if (!up && !dn)
                    begin
                        state_next = ST_WAIT;
                    end
                end
                default:
                begin
                    // The start state ignores the buttons on its first pass.
                    state_next = ST_WAIT;
                end
            endcase

            if (state_next == ST_WAIT)
            begin
                hold_mid   = '0;
                phase_next = PHASE_POLL;
            end
            else if (state_next == ST_CLEAR)
            begin
                count_next = '0;
            end
            elapsed_mid = '0;
        end
        else
        begin
            elapsed_mid = elapsed_reg;
        end

        // Both timers count up once per tick and stick at their maximum.
        elapsed_next = (elapsed_mid == TIME_MAX) ? elapsed_mid
                                                 : elapsed_mid + budc_time_t'(1);
        hold_next    = (hold_mid == TIME_MAX) ? hold_mid : hold_mid + budc_time_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_START;
            count_reg   <= '0;
            phase_reg   <= PHASE_POLL;
            elapsed_reg <= ELAPSED_RST;
            hold_reg    <= '0;
        end
        else if (in_accept)
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
        end
    end

    // The result register takes the count after this tick's evaluation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_count_reg <= count_next;
        end
    end

endmodule
